### rtl/n2w_pkg.sv
// shared types and constants for the number to word tokens block
`default_nettype none
package n2w_pkg;

    localparam int VALUE_W   = 32;
    localparam int CNT_W     = $clog2(VALUE_W);
    localparam int NUM_DIG   = 10;
    localparam int DIG_W     = 4;
    localparam int BCD_W     = NUM_DIG * DIG_W;
    localparam int TOK_W     = 5;
    localparam int NUM_GRP   = 4;
    localparam int GRP_SLOTS = 5;
    localparam int NSLOT     = NUM_GRP * GRP_SLOTS + 1;
    localparam int SLOT_W    = $clog2(NSLOT);
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [TOK_W-1:0] TOK_ZERO      = 5'd0;
    localparam logic [TOK_W-1:0] TOK_TEEN_BASE = 5'd10;
    localparam logic [TOK_W-1:0] TOK_TENS_BASE = 5'd18;
    localparam logic [TOK_W-1:0] TOK_HUNDRED   = 5'd28;

    typedef logic [NUM_DIG-1:0][DIG_W-1:0] bcd_t;
    typedef logic [TOK_W-1:0] token_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } front_state_t;

endpackage
`default_nettype wire

### rtl/n2w_front.sv
// front end: accepts a value and converts it to decimal digits bit by bit
`default_nettype none
module n2w_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [n2w_pkg::VALUE_W-1:0]   s_value,
    output logic                               q_valid,
    input  wire logic                          q_ready,
    output n2w_pkg::bcd_t                      q_digits
);
    import n2w_pkg::*;

    front_state_t       state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [VALUE_W-1:0] bin_reg;
    bcd_t               bcd_reg;
    bcd_t               adj;
    logic [BCD_W-1:0]   adj_flat;

    // add three to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIG; i++) begin
            if (bcd_reg[i] >= 4'd5) begin
                adj[i] = bcd_reg[i] + 4'd3;
            end else begin
                adj[i] = bcd_reg[i];
            end
        end
        adj_flat = adj;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    state_next = F_CONV;
                end
            end
            F_CONV: begin
                if (cnt_reg == CNT_W'(VALUE_W - 1)) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (q_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        q_valid = 1'b0;
        case (state_reg)
            F_IDLE:  s_ready = 1'b1;
            F_PUSH:  q_valid = 1'b1;
            default: begin
                s_ready = 1'b0;
                q_valid = 1'b0;
            end
        endcase
    end

    assign q_digits = bcd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (s_valid && s_ready) begin
                cnt_reg <= '0;
            end else if (state_reg == F_CONV) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            bin_reg <= s_value;
            bcd_reg <= '0;
        end else if (state_reg == F_CONV) begin
            bcd_reg <= {adj_flat[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_reg <= {bin_reg[VALUE_W-2:0], 1'b0};
        end
    end

endmodule
`default_nettype wire

### rtl/n2w_fifo.sv
// short queue of converted digit words between front and back
`default_nettype none
module n2w_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  n2w_pkg::bcd_t      wr_data,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output n2w_pkg::bcd_t      rd_data
);
    import n2w_pkg::*;

    bcd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign wr_ready = (count_reg != QCNT_W'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_ptrs_on_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers differ while empty");

    a_pop_updates: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !push |=> count_reg == $past(count_reg) - QCNT_W'(1))
        else $error("queue count missed a pop");

endmodule
`default_nettype wire

### rtl/n2w_back.sv
// back end: sets out a number's token slots, sends one per cycle unless stalled
`default_nettype none
module n2w_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       q_valid,
    output logic                            q_ready,
    input  n2w_pkg::bcd_t                   q_digits,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [n2w_pkg::TOK_W-1:0]       m_word,
    output logic                            m_last
);
    import n2w_pkg::*;

    localparam int PAD_DIG = NUM_GRP * 3;

    logic [NSLOT-1:0]  mask_reg, mask_next;
    token_t            tok_reg [NSLOT];
    logic [NSLOT-1:0]  ld_mask;
    token_t            ld_tok [NSLOT];
    logic [PAD_DIG-1:0][DIG_W-1:0] dig;
    logic [SLOT_W-1:0] first_idx;
    logic [NSLOT-1:0]  first_oh;
    logic              load;

    // slots per group, most significant group first:
    // hundreds digit, hundred, tens or teen, unit, scale word; then the lone zero
    always_comb begin
        dig = '0;
        dig[NUM_DIG-1:0] = q_digits;
        for (int k = 0; k < NUM_GRP; k++) begin
            logic [DIG_W-1:0] h, t, u;
            int               b;
            h = dig[3*k+2];
            t = dig[3*k+1];
            u = dig[3*k];
            b = (NUM_GRP - 1 - k) * GRP_SLOTS;
            ld_mask[b]   = (h != '0);
            ld_tok[b]    = {1'b0, h};
            ld_mask[b+1] = (h != '0);
            ld_tok[b+1]  = TOK_HUNDRED;
            ld_mask[b+2] = (t != '0);
            ld_tok[b+2]  = (t == 4'd1) ? TOK_TEEN_BASE + {1'b0, u} : TOK_TENS_BASE + {1'b0, t};
            ld_mask[b+3] = (t != 4'd1) && (u != '0);
            ld_tok[b+3]  = {1'b0, u};
            ld_mask[b+4] = (k != 0) && ((h != '0) || (t != '0) || (u != '0));
            ld_tok[b+4]  = TOK_HUNDRED + TOK_W'(k);
        end
        ld_mask[NSLOT-1] = (q_digits == '0);
        ld_tok[NSLOT-1]  = TOK_ZERO;
    end

    // lowest pending slot goes out next
    always_comb begin
        first_idx = '0;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                first_idx = SLOT_W'(i);
            end
        end
        first_oh = NSLOT'(1) << first_idx;
    end

    assign m_valid = (mask_reg != '0);
    assign m_word  = tok_reg[first_idx];
    assign m_last  = ((mask_reg & ~first_oh) == '0);
    assign load    = q_valid && (!m_valid || (m_ready && m_last));
    assign q_ready = load;

    always_comb begin
        mask_next = mask_reg;
        if (load) begin
            mask_next = ld_mask;
        end else if (m_valid && m_ready) begin
            mask_next = mask_reg & ~first_oh;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < NSLOT; i++) begin
                tok_reg[i] <= ld_tok[i];
            end
        end
    end

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("token run ended before its last item");

    a_last_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> $countones(mask_reg) == 1)
        else $error("last flag with more slots pending");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |-> !m_valid || (m_ready && m_last))
        else $error("new number loaded over a pending run");

endmodule
`default_nettype wire

### rtl/number_to_word_tokens.sv
// top level: unsigned value in, run of english word tokens out
//
//  channel | ports                        | carries
//  --------+------------------------------+------------------------------------
//  input   | s_valid s_ready s_value[31:0]| one value per item
//  result  | m_valid m_ready m_word m_last| one token per item, last ends a run
//
// the front converts a value to decimal one bit per cycle, then hands it
// to a two-entry queue; it takes a new value only once it is idle again.
// the back sends 1 to 16 tokens, one per cycle while m_ready is high; the first
// token appears once the digits have passed through the queue into the back.
// reset is synchronous and clears all control state; a stalled result channel
// backs up through the queue into the front without loss.
`default_nettype none
module number_to_word_tokens (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [n2w_pkg::VALUE_W-1:0]   s_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [n2w_pkg::TOK_W-1:0]          m_word,
    output logic                               m_last
);
    import n2w_pkg::*;

    logic fq_valid, fq_ready;
    bcd_t fq_digits;
    logic qb_valid, qb_ready;
    bcd_t qb_digits;

    n2w_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_value  (s_value),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_digits (fq_digits)
    );

    n2w_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_digits),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_digits)
    );

    n2w_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_digits (qb_digits),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_word   (m_word),
        .m_last   (m_last)
    );

endmodule
`default_nettype wire
